// ----- hdl/fmprt_pkg.sv -----
// ----------------------------------------------------------------------------
// fmprt_pkg
// shared types and codes for the first-match packet rule table
// ----------------------------------------------------------------------------
`default_nettype none

package fmprt_pkg;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_DISABLE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam logic ACT_ACCEPT = 1'b0;

    typedef struct packed {
        logic        action;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    function automatic logic field_hit(input logic [31:0] rule_val,
                                       input logic [31:0] pkt_val);
        field_hit = (rule_val == 32'd0) || (rule_val == pkt_val);
    endfunction

    function automatic logic rule_hit(input rule_t r, input rule_t p);
        rule_hit = field_hit(r.src_addr, p.src_addr)
                && field_hit(r.dst_addr, p.dst_addr)
                && field_hit({16'd0, r.sport}, {16'd0, p.sport})
                && field_hit({16'd0, r.dport}, {16'd0, p.dport})
                && field_hit({24'd0, r.protocol}, {24'd0, p.protocol});
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fmprt_ram.sv -----
// ----------------------------------------------------------------------------
// fmprt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module fmprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/first_match_packet_rule_table.sv -----
// ----------------------------------------------------------------------------
// first_match_packet_rule_table
// ordered five-tuple rule table, rules held in ram, checks scan in order
// ----------------------------------------------------------------------------
// flow: add, disable and unused opcodes go through the result registers in
//   S_DONE to the output register; a check first scans the added rules
// throughput: one item at a time; a check scan reads one stored rule per cycle
//   from the ram and stops at the first hit; S_DONE holds while the output stalls
// reset: rule count clears at once; ram contents, enables included, are left
//   as is, entries at or above the rule count are never read
`default_nettype none

module first_match_packet_rule_table #(
    parameter int MAX_RULES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic        rule_action,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] destination_address,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] destination_port,
    input  wire logic [7:0]  protocol_number,
    input  wire logic [5:0]  rule_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             verdict,
    output logic [1:0]       status
);

    import fmprt_pkg::*;

    localparam int CW   = $clog2(MAX_RULES + 1);
    localparam int AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CMPW = (CW > 6) ? CW : 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          res_verdict_reg, res_verdict_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic          verdict_reg, verdict_next;
    logic [1:0]    status_reg, status_next;
    rule_t         pkt_reg;

    rule_t         in_rule;
    rule_t         rd_rule;
    logic          rd_enable;
    logic          accept;
    logic          full;
    logic          idx_ok;

    logic          rule_we;
    logic          en_we;
    logic          en_wdata;
    logic [AW-1:0] en_waddr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign in_rule = '{action:   rule_action,
                       protocol: protocol_number,
                       src_addr: source_address,
                       dst_addr: destination_address,
                       sport:    source_port,
                       dport:    destination_port};

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(MAX_RULES));
    assign idx_ok   = (CMPW'(rule_index) < CMPW'(count_reg));

    fmprt_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .clk     (clk),
        .wr_en   (rule_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_rule),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rule)
    );

    fmprt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_RULES)
    ) u_enable_ram (
        .clk     (clk),
        .wr_en   (en_we),
        .wr_addr (en_waddr),
        .wr_data (en_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_enable)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        res_verdict_next = res_verdict_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        verdict_next     = verdict_reg;
        status_next      = status_reg;
        rule_we          = 1'b0;
        en_we            = 1'b0;
        en_wdata         = 1'b0;
        en_waddr         = count_reg[AW-1:0];
        rd_en            = 1'b0;
        rd_addr          = issue_reg[AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_verdict_next = ACT_ACCEPT;
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                    case (opcode)
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                rule_we    = 1'b1;
                                en_we      = 1'b1;
                                en_wdata   = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DISABLE:
                        begin
                            if (idx_ok)
                            begin
                                en_we    = 1'b1;
                                en_wdata = 1'b0;
                                en_waddr = AW'(CMPW'(rule_index));
                            end
                            else
                            begin
                                res_status_next = ST_BAD_INDEX;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                issue_next = CW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_enable && rule_hit(rd_rule, pkt_reg))
                begin
                    res_verdict_next = rd_rule.action;
                    state_next       = S_DONE;
                end
                else if (issue_reg == count_reg)
                begin
                    res_verdict_next = ACT_ACCEPT;
                    state_next       = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = res_verdict_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            issue_reg       <= '0;
            res_verdict_reg <= 1'b0;
            res_status_reg  <= ST_OK;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= 1'b0;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            issue_reg       <= issue_next;
            res_verdict_reg <= res_verdict_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            verdict_reg     <= verdict_next;
            status_reg      <= status_next;
        end
    end

    // packet fields held for the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pkt_reg <= in_rule;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count beyond table size");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_ADD) && full |=> $stable(count_reg))
        else $error("add on full table changed the rule count");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg != '0) && (issue_reg <= count_reg))
        else $error("scan index outside added rules");

    a_check_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_CHECK) |=> (res_status_reg == ST_OK))
        else $error("check item carries a non-ok status");

endmodule

`default_nettype wire

// ----- tb/first_match_packet_rule_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_match_packet_rule_table_test
// drives rule adds, disables, packet checks and unused opcodes with random
// sender bursts and receiver stalls; a local rule store predicts each verdict
// and status, and every result is compared in order against it
// ----------------------------------------------------------------------------

module first_match_packet_rule_table_test;

    import fmprt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 375;
    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic ACT_DROP = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        action;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [5:0]  rule_idx;
    } cmd_t;

    typedef struct packed {
        logic       verdict;
        logic [1:0] status;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic verdict;
    logic [1:0] status;
    cmd_t drive_cmd = '0;

    cmd_t pending_cmds[$];
    outcome_t expected_outcomes[$];
    rule_t gen_rules[$];
    logic [31:0] value_pool[8];

    rule_t rule_store[TABLE_DEPTH];
    logic rule_live[TABLE_DEPTH];
    int stored_rules = 0;

    int burst_left = 0;
    int gap_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0] ready_phase = 4'd0;
    outcome_t wanted;
    int mismatch_count = 0;
    int cycle_count = 0;

    first_match_packet_rule_table #(
        .MAX_RULES (TABLE_DEPTH)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (drive_cmd.opcode),
        .rule_action         (drive_cmd.action),
        .source_address      (drive_cmd.src_addr),
        .destination_address (drive_cmd.dst_addr),
        .source_port         (drive_cmd.sport),
        .destination_port    (drive_cmd.dport),
        .protocol_number     (drive_cmd.protocol),
        .rule_index          (drive_cmd.rule_idx),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .verdict             (verdict),
        .status              (status)
    );

    always #4 clk = ~clk;

    // expected verdict and status of one item, updating the local rule store
    function automatic outcome_t judge_item(input cmd_t c);
        outcome_t o;
        logic found;
        int i;
        o.verdict = ACT_ACCEPT;
        o.status = ST_OK;
        found = 1'b0;
        case (c.opcode)
            OP_ADD:
            begin
                if (stored_rules >= TABLE_DEPTH)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    rule_store[stored_rules].action = c.action;
                    rule_store[stored_rules].src_addr = c.src_addr;
                    rule_store[stored_rules].dst_addr = c.dst_addr;
                    rule_store[stored_rules].sport = c.sport;
                    rule_store[stored_rules].dport = c.dport;
                    rule_store[stored_rules].protocol = c.protocol;
                    rule_live[stored_rules] = 1'b1;
                    stored_rules++;
                end
            end
            OP_DISABLE:
            begin
                if (c.rule_idx >= stored_rules)
                    o.status = ST_BAD_INDEX;
                else
                    rule_live[c.rule_idx] = 1'b0;
            end
            OP_CHECK:
            begin
                for (i = 0; i < stored_rules && !found; i++)
                begin
                    if (rule_live[i]
                        && (rule_store[i].src_addr == 0 || rule_store[i].src_addr == c.src_addr)
                        && (rule_store[i].dst_addr == 0 || rule_store[i].dst_addr == c.dst_addr)
                        && (rule_store[i].sport == 0 || rule_store[i].sport == c.sport)
                        && (rule_store[i].dport == 0 || rule_store[i].dport == c.dport)
                        && (rule_store[i].protocol == 0 || rule_store[i].protocol == c.protocol))
                    begin
                        o.verdict = rule_store[i].action;
                        found = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // wildcard, a shared value that other rules may also use, or fully random
    function automatic logic [31:0] rule_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'd0;
        else if (r < 7)
            return value_pool[$urandom_range(0, 7)];
        else
            return $urandom;
    endfunction

    // packet field that satisfies a rule field, random where the rule is a wildcard
    function automatic logic [31:0] packet_field(input logic [31:0] rule_val);
        if (rule_val != 32'd0)
            return rule_val;
        else if ($urandom_range(0, 4) == 0)
            return 32'd0;
        else if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        else
            return $urandom;
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic act,
                              input logic [31:0] sa, input logic [31:0] da,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input logic [7:0] pr, input logic [5:0] idx);
        cmd_t c;
        rule_t r;
        c.opcode = op;
        c.action = act;
        c.src_addr = sa;
        c.dst_addr = da;
        c.sport = sp;
        c.dport = dp;
        c.protocol = pr;
        c.rule_idx = idx;
        pending_cmds.push_back(c);
        if (op == OP_ADD && gen_rules.size() < TABLE_DEPTH)
        begin
            r.action = act;
            r.src_addr = sa;
            r.dst_addr = da;
            r.sport = sp;
            r.dport = dp;
            r.protocol = pr;
            gen_rules.push_back(r);
        end
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_outcomes.push_back(judge_item(drive_cmd));
            if (in_valid && !in_ready)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                drive_cmd <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left <= burst_left - 1;
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    burst_left <= $urandom_range(20, 60);
                    gap_left <= 0;
                end
                else
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= $urandom_range(1, 20);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stalls follow a 16-bit pattern that is redrawn each period
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_pattern <= 16'hFFFF;
            ready_phase <= 4'd0;
        end
        else
        begin
            out_ready <= ready_pattern[ready_phase];
            ready_phase <= ready_phase + 4'd1;
            if (ready_phase == 4'd15)
                ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no item outstanding: verdict %0d status %0d",
                       verdict, status);
                mismatch_count++;
            end
            else
            begin
                wanted = expected_outcomes.pop_front();
                if (verdict !== wanted.verdict)
                begin
                    $error("verdict mismatch: expected %0d, actual %0d",
                           wanted.verdict, verdict);
                    mismatch_count++;
                end
                if (status !== wanted.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           wanted.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int n;
        int pick;
        int add_pct;
        int count;
        int k;
        rule_t base;
        logic [1:0] op;
        logic act;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0] pr;
        logic [5:0] idx;

        for (n = 0; n < 8; n++)
            value_pool[n] = $urandom;

        // empty table, bad index on empty table, unused opcode
        queue_item(OP_CHECK, 1'b1, '0, '0, '0, '0, '0, '0);
        queue_item(OP_CHECK, 1'b1, '1, '1, '1, '1, '1, '1);
        queue_item(OP_DISABLE, 1'b0, '0, '0, '0, '0, '0, 6'd0);
        queue_item(OP_UNUSED, 1'b1, '1, '1, '1, '1, '1, '1);
        // full wildcard rule, then disabled twice
        queue_item(OP_ADD, ACT_DROP, '0, '0, '0, '0, '0, '0);
        queue_item(OP_CHECK, 1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                   8'($urandom), '0);
        queue_item(OP_DISABLE, 1'b0, '0, '0, '0, '0, '0, 6'd0);
        queue_item(OP_DISABLE, 1'b1, '1, '1, '1, '1, '1, 6'd0);
        queue_item(OP_CHECK, 1'b0, '1, '1, '1, '1, '1, '0);
        // all fields at their maximum
        queue_item(OP_ADD, ACT_DROP, '1, '1, '1, '1, '1, '1);
        queue_item(OP_CHECK, 1'b0, '1, '1, '1, '1, '1, '0);
        queue_item(OP_CHECK, 1'b0, '1, '1, '1, '1, 8'hFE, '0);
        queue_item(OP_CHECK, 1'b0, '1, '1, 16'h7FFF, '1, '1, '0);
        // first match wins over a later rule with the same fields
        queue_item(OP_ADD, ACT_ACCEPT, 32'd1, '0, '0, '0, '0, '0);
        queue_item(OP_ADD, ACT_DROP, 32'd1, '0, '0, '0, '0, '0);
        queue_item(OP_CHECK, 1'b1, 32'd1, $urandom, 16'($urandom), 16'($urandom),
                   8'($urandom), '0);
        queue_item(OP_DISABLE, 1'b0, '0, '0, '0, '0, '0, 6'd2);
        queue_item(OP_CHECK, 1'b0, 32'd1, $urandom, 16'($urandom), 16'($urandom),
                   8'($urandom), '0);
        // index just past the rule count, and the highest index
        queue_item(OP_DISABLE, 1'b0, '0, '0, '0, '0, '0, 6'd4);
        queue_item(OP_DISABLE, 1'b1, '1, '1, '1, '1, '1, 6'd63);
        queue_item(OP_ADD, ACT_DROP, '0, '0, '0, 16'd80, 8'd6, '0);
        queue_item(OP_CHECK, 1'b0, $urandom, $urandom, 16'($urandom), 16'd80, 8'd6, '0);
        queue_item(OP_CHECK, 1'b0, $urandom, $urandom, 16'($urandom), 16'd80, 8'd17, '0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            count = gen_rules.size();
            pick = $urandom_range(0, 99);
            add_pct = (count < TABLE_DEPTH) ? 35 : 8;
            act = 1'($urandom);
            idx = 6'($urandom);
            if (pick < add_pct)
            begin
                op = OP_ADD;
                sa = rule_field();
                da = rule_field();
                sp = 16'(rule_field());
                dp = 16'(rule_field());
                pr = 8'(rule_field());
            end
            else
            begin
                sa = $urandom;
                da = $urandom;
                sp = 16'($urandom);
                dp = 16'($urandom);
                pr = 8'($urandom);
                if (pick < add_pct + 10)
                begin
                    op = OP_DISABLE;
                    if (count > 0 && ($urandom_range(0, 3) != 0 || count == TABLE_DEPTH))
                        idx = 6'($urandom_range(0, count - 1));
                    else
                        idx = 6'($urandom_range(count, TABLE_DEPTH - 1));
                end
                else if (pick < add_pct + 14)
                begin
                    op = OP_UNUSED;
                end
                else
                begin
                    op = OP_CHECK;
                    if (count > 0 && $urandom_range(0, 3) != 0)
                        base = gen_rules[$urandom_range(0, count - 1)];
                    else
                        base = '0;
                    sa = packet_field(base.src_addr);
                    da = packet_field(base.dst_addr);
                    sp = 16'(packet_field({16'd0, base.sport}));
                    dp = 16'(packet_field({16'd0, base.dport}));
                    pr = 8'(packet_field({24'd0, base.protocol}));
                    // near miss on one field
                    if ($urandom_range(0, 9) < 3)
                    begin
                        k = $urandom_range(0, 4);
                        case (k)
                            0: sa = $urandom;
                            1: da = $urandom;
                            2: sp = 16'($urandom);
                            3: dp = 16'($urandom);
                            default: pr = 8'($urandom);
                        endcase
                    end
                end
            end
            queue_item(op, act, sa, da, sp, dp, pr, idx);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- first_match_packet_rule_table.f -----
hdl/fmprt_pkg.sv
hdl/fmprt_ram.sv
hdl/first_match_packet_rule_table.sv
tb/first_match_packet_rule_table_test.sv
